FILE: hw/rtl/pcls_pkg.sv
package pcls_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int ADDR_W      = 16;
    localparam int MAX_PIXELS  = 1 << ADDR_W;
    localparam int CNT_W       = ADDR_W + 1;
    localparam int BIN_W       = 10;
    localparam int NBINS       = 1 << BIN_W;
    localparam int HIST_W      = CNT_W;
    localparam int PERMILLE_W  = 9;
    localparam int LEVEL_W     = 8;
    localparam int DIV_NUM_W   = 27;
    localparam int DIV_DEN_W   = 17;
    localparam int DIV_Q_W     = 17;
    localparam int DIV_CNT_W   = 5;
    localparam int PROD_W      = BIN_W + 1 + SAMPLE_W;

    // divide by 1000 as multiply by ceil(2^35 / 1000), exact below 2^25
    localparam int CLIP_RECIP_W = 26;
    localparam int CLIP_SHIFT   = 35;
    localparam int CLIP_MUL_W   = PROD_W + CLIP_RECIP_W;

    localparam logic [PERMILLE_W-1:0]   PERMILLE_RESET = PERMILLE_W'(20);
    localparam logic [CLIP_RECIP_W-1:0] CLIP_RECIP     = CLIP_RECIP_W'(34359739);
    localparam logic [LEVEL_W-1:0]      LEVEL_MAX      = LEVEL_W'(255);

    // command codes on the input tuser
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CLR,
        S_CLIP,
        S_CLIP_W,
        S_H_RD,
        S_H_DIV,
        S_H_DIVW,
        S_H_HRD,
        S_H_WR,
        S_L_RD,
        S_L_CHK,
        S_L_SET,
        S_U_RD,
        S_U_CHK,
        S_U_SET,
        S_R_CALC,
        S_R_DIVW,
        S_R_OUT
    } t_state;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } t_div_req;

endpackage

FILE: hw/rtl/percentile_clip_linear_stretch.sv
// load item: stored on accept; the frame_end load then builds: clear all 1024 bins,
//   clip count, bin each sample via the serial divider, scan bins from each end
// read item: in-range pixels go through the serial divider, pixels at or outside
//   the bounds skip it; each result waits until the output register is free
// reset: synchronous, active low; clears control, bounds and counts, permille to 20;
//   no memory clearing pass, the histogram is cleared at the start of each build
module percentile_clip_linear_stretch (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input item stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [15:0] sample
    input  logic        i_s_tuser,   // [0] cmd
    input  logic        i_s_tlast,   // frame_end
    // result item stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // [7:0] level
    output logic        o_m_tlast,   // final_pixel
    // clip_permille write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [8:0]  i_cfg_data
);

    localparam int SW = pcls_pkg::SAMPLE_W;
    localparam int CW = pcls_pkg::CNT_W;
    localparam int BW = pcls_pkg::BIN_W;
    localparam int HW = pcls_pkg::HIST_W;

    pcls_pkg::t_state r_state, n_state;

    logic [pcls_pkg::PERMILLE_W-1:0] r_permille;
    logic                 r_phase, n_phase;
    logic [SW-1:0]        r_min, n_min;
    logic [SW-1:0]        r_max, n_max;
    logic [CW-1:0]        r_cnt, n_cnt;
    logic [CW-1:0]        r_idx, n_idx;
    logic [CW-1:0]        r_rptr, n_rptr;
    logic [SW-1:0]        r_low, n_low;
    logic [SW-1:0]        r_high, n_high;
    logic [CW-1:0]        r_clip, n_clip;
    logic [HW-1:0]        r_acc, n_acc;
    logic [BW-1:0]        r_bin, n_bin;
    logic [BW-1:0]        r_binsel, n_binsel;
    logic [pcls_pkg::PROD_W-1:0] r_prod, n_prod;
    logic                 r_out_valid, n_out_valid;
    logic [7:0]           r_out_level, n_out_level;
    logic                 r_out_last, n_out_last;
    logic [7:0]           r_level, n_level;

    // memory ports
    logic                 st_we;
    logic [pcls_pkg::ADDR_W-1:0] st_waddr, st_raddr;
    logic [SW-1:0]        st_wdata, st_rdata;
    logic                 hi_we;
    logic [BW-1:0]        hi_waddr, hi_raddr;
    logic [HW-1:0]        hi_wdata, hi_rdata;

    pcls_pkg::t_div_req   div_req;
    logic                 div_done;
    logic [pcls_pkg::DIV_Q_W-1:0] div_quot;

    // scratch
    logic                 in_acc;
    logic [CW-1:0]        base_cnt, cnt_inc;
    logic [SW-1:0]        base_min, base_max;
    logic [SW-1:0]        span;
    logic [HW-1:0]        acc_sum;
    logic                 out_free;
    logic [pcls_pkg::CLIP_MUL_W-1:0] clip_mul;

    pcls_ram #(.WIDTH(SW), .DEPTH(pcls_pkg::MAX_PIXELS)) u_store (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    pcls_ram #(.WIDTH(HW), .DEPTH(pcls_pkg::NBINS)) u_hist (
        .i_clk   (i_clk),
        .i_we    (hi_we),
        .i_waddr (hi_waddr),
        .i_wdata (hi_wdata),
        .i_raddr (hi_raddr),
        .o_rdata (hi_rdata)
    );

    pcls_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign o_s_tready  = (r_state == pcls_pkg::S_IDLE);
    assign in_acc      = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out_level;
    assign o_m_tlast   = r_out_last;
    assign out_free    = !r_out_valid || i_m_tready;
    assign span        = r_max - r_min;
    // clip count: count * permille / 1000 by reciprocal multiply
    assign clip_mul    = r_prod * pcls_pkg::CLIP_RECIP;

    // sequencer: load, histogram build, bound scans, pixel read
    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_min       = r_min;
        n_max       = r_max;
        n_cnt       = r_cnt;
        n_idx       = r_idx;
        n_rptr      = r_rptr;
        n_low       = r_low;
        n_high      = r_high;
        n_clip      = r_clip;
        n_acc       = r_acc;
        n_bin       = r_bin;
        n_binsel    = r_binsel;
        n_prod      = r_prod;
        n_level     = r_level;
        n_out_valid = r_out_valid;
        n_out_level = r_out_level;
        n_out_last  = r_out_last;

        st_we    = 1'b0;
        st_waddr = '0;
        st_wdata = i_s_tdata;
        st_raddr = r_rptr[pcls_pkg::ADDR_W-1:0];
        hi_we    = 1'b0;
        hi_waddr = r_bin;
        hi_wdata = '0;
        hi_raddr = r_bin;
        div_req  = '0;

        base_cnt = r_phase ? '0 : r_cnt;
        base_min = r_phase ? '1 : r_min;
        base_max = r_phase ? '0 : r_max;
        cnt_inc  = base_cnt;
        acc_sum  = r_acc + hi_rdata;

        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            pcls_pkg::S_IDLE: begin
                if (in_acc && i_s_tuser == pcls_pkg::CMD_LOAD) begin
                    // a load while reading starts a new frame
                    n_phase = 1'b0;
                    n_rptr  = '0;
                    n_min   = base_min;
                    n_max   = base_max;
                    n_cnt   = base_cnt;
                    if (base_cnt < CW'(pcls_pkg::MAX_PIXELS)) begin
                        st_we    = 1'b1;
                        st_waddr = base_cnt[pcls_pkg::ADDR_W-1:0];
                        cnt_inc  = base_cnt + 1'b1;
                        n_cnt    = cnt_inc;
                        if (i_s_tdata < base_min) n_min = i_s_tdata;
                        if (i_s_tdata > base_max) n_max = i_s_tdata;
                    end
                    if (i_s_tlast && cnt_inc != '0) begin
                        n_bin   = '0;
                        n_state = pcls_pkg::S_CLR;
                    end
                end else if (in_acc && r_phase && r_rptr < r_cnt) begin
                    n_state = pcls_pkg::S_R_CALC;
                end
            end
            pcls_pkg::S_CLR: begin
                hi_we = 1'b1;
                n_bin = r_bin + 1'b1;
                if (r_bin == BW'(pcls_pkg::NBINS - 1)) begin
                    n_state = pcls_pkg::S_CLIP;
                end
            end
            pcls_pkg::S_CLIP: begin
                n_prod  = pcls_pkg::PROD_W'(r_cnt * r_permille);
                n_state = pcls_pkg::S_CLIP_W;
            end
            pcls_pkg::S_CLIP_W: begin
                n_clip  = clip_mul[pcls_pkg::CLIP_SHIFT+CW-1:pcls_pkg::CLIP_SHIFT];
                n_idx   = '0;
                n_state = pcls_pkg::S_H_RD;
            end
            pcls_pkg::S_H_RD: begin
                st_raddr = r_idx[pcls_pkg::ADDR_W-1:0];
                n_state  = pcls_pkg::S_H_DIV;
            end
            pcls_pkg::S_H_DIV: begin
                // bin = (v - min) * NBINS / (span + 1)
                div_req.start = 1'b1;
                div_req.num   = pcls_pkg::DIV_NUM_W'({st_rdata - r_min, {BW{1'b0}}});
                div_req.den   = pcls_pkg::DIV_DEN_W'(span) + 1'b1;
                n_state       = pcls_pkg::S_H_DIVW;
            end
            pcls_pkg::S_H_DIVW: begin
                if (div_done) begin
                    n_binsel = div_quot[BW-1:0];
                    n_state  = pcls_pkg::S_H_HRD;
                end
            end
            pcls_pkg::S_H_HRD: begin
                hi_raddr = r_binsel;
                n_state  = pcls_pkg::S_H_WR;
            end
            pcls_pkg::S_H_WR: begin
                hi_we    = 1'b1;
                hi_waddr = r_binsel;
                hi_wdata = hi_rdata + 1'b1;
                n_idx    = r_idx + 1'b1;
                if (r_idx + 1'b1 == r_cnt) begin
                    n_bin   = '0;
                    n_acc   = '0;
                    n_state = pcls_pkg::S_L_RD;
                end else begin
                    n_state = pcls_pkg::S_H_RD;
                end
            end
            pcls_pkg::S_L_RD: begin
                n_state = pcls_pkg::S_L_CHK;
            end
            pcls_pkg::S_L_CHK: begin
                // running sum from the low end
                if (acc_sum >= r_clip) begin
                    n_prod  = pcls_pkg::PROD_W'(({1'b0, r_bin} + 1'b1) * span);
                    n_state = pcls_pkg::S_L_SET;
                end else begin
                    n_acc   = acc_sum;
                    n_bin   = r_bin + 1'b1;
                    n_state = pcls_pkg::S_L_RD;
                end
            end
            pcls_pkg::S_L_SET: begin
                n_low   = SW'(r_prod >> BW) + r_min;
                n_bin   = BW'(pcls_pkg::NBINS - 1);
                n_acc   = '0;
                n_state = pcls_pkg::S_U_RD;
            end
            pcls_pkg::S_U_RD: begin
                n_state = pcls_pkg::S_U_CHK;
            end
            pcls_pkg::S_U_CHK: begin
                // running sum from the high end
                if (acc_sum >= r_clip) begin
                    n_prod  = pcls_pkg::PROD_W'(r_bin * span);
                    n_state = pcls_pkg::S_U_SET;
                end else begin
                    n_acc   = acc_sum;
                    n_bin   = r_bin - 1'b1;
                    n_state = pcls_pkg::S_U_RD;
                end
            end
            pcls_pkg::S_U_SET: begin
                n_high  = SW'(r_prod >> BW) + r_min;
                n_phase = 1'b1;
                n_rptr  = '0;
                n_state = pcls_pkg::S_IDLE;
            end
            pcls_pkg::S_R_CALC: begin
                if (st_rdata <= r_low) begin
                    n_level = '0;
                    n_state = pcls_pkg::S_R_OUT;
                end else if (st_rdata >= r_high) begin
                    n_level = pcls_pkg::LEVEL_MAX;
                    n_state = pcls_pkg::S_R_OUT;
                end else begin
                    div_req.start = 1'b1;
                    div_req.num   = pcls_pkg::DIV_NUM_W'((st_rdata - r_low)
                                    * pcls_pkg::LEVEL_MAX);
                    div_req.den   = pcls_pkg::DIV_DEN_W'(r_high - r_low);
                    n_state       = pcls_pkg::S_R_DIVW;
                end
            end
            pcls_pkg::S_R_DIVW: begin
                if (div_done) begin
                    n_level = div_quot[7:0];
                    n_state = pcls_pkg::S_R_OUT;
                end
            end
            pcls_pkg::S_R_OUT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_level = r_level;
                    n_out_last  = (r_rptr + 1'b1 == r_cnt);
                    n_rptr      = r_rptr + 1'b1;
                    if (r_rptr + 1'b1 == r_cnt) begin
                        // frame finished: back to loading
                        n_phase = 1'b0;
                        n_cnt   = '0;
                        n_min   = '1;
                        n_max   = '0;
                        n_rptr  = '0;
                    end
                    n_state = pcls_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pcls_pkg::S_IDLE;
            end
        endcase
    end

    // control, bound and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pcls_pkg::S_IDLE;
            r_permille  <= pcls_pkg::PERMILLE_RESET;
            r_phase     <= 1'b0;
            r_min       <= '1;
            r_max       <= '0;
            r_cnt       <= '0;
            r_rptr      <= '0;
            r_low       <= '0;
            r_high      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            if (i_cfg_valid) begin
                r_permille <= i_cfg_data;
            end
            r_phase     <= n_phase;
            r_min       <= n_min;
            r_max       <= n_max;
            r_cnt       <= n_cnt;
            r_rptr      <= n_rptr;
            r_low       <= n_low;
            r_high      <= n_high;
            r_out_valid <= n_out_valid;
        end
        r_idx       <= n_idx;
        r_clip      <= n_clip;
        r_acc       <= n_acc;
        r_bin       <= n_bin;
        r_binsel    <= n_binsel;
        r_prod      <= n_prod;
        r_level     <= n_level;
        r_out_level <= n_out_level;
        r_out_last  <= n_out_last;
    end

endmodule

FILE: hw/rtl/pcls_ram.sv
module pcls_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/pcls_div.sv
module pcls_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  pcls_pkg::t_div_req                i_req,
    output logic                              o_done,
    output logic [pcls_pkg::DIV_Q_W-1:0]      o_quot
);

    localparam int SH_W = pcls_pkg::DIV_DEN_W + pcls_pkg::DIV_Q_W - 1;

    logic                               r_busy, n_busy;
    logic                               r_done, n_done;
    logic [pcls_pkg::DIV_CNT_W-1:0]     r_cnt, n_cnt;
    logic [pcls_pkg::DIV_NUM_W-1:0]     r_rem, n_rem;
    logic [SH_W-1:0]                    r_den_sh, n_den_sh;
    logic [pcls_pkg::DIV_Q_W-1:0]       r_q, n_q;
    logic [SH_W-1:0]                    rem_ext;

    // restoring division, one quotient bit per cycle
    always_comb begin
        n_busy   = r_busy;
        n_done   = 1'b0;
        n_cnt    = r_cnt;
        n_rem    = r_rem;
        n_den_sh = r_den_sh;
        n_q      = r_q;
        rem_ext  = SH_W'(r_rem);
        if (i_req.start) begin
            n_busy   = 1'b1;
            n_cnt    = '0;
            n_rem    = i_req.num;
            n_den_sh = {i_req.den, {(pcls_pkg::DIV_Q_W-1){1'b0}}};
            n_q      = '0;
        end else if (r_busy) begin
            if (rem_ext >= r_den_sh) begin
                n_rem = r_rem - pcls_pkg::DIV_NUM_W'(r_den_sh);
                n_q   = {r_q[pcls_pkg::DIV_Q_W-2:0], 1'b1};
            end else begin
                n_q   = {r_q[pcls_pkg::DIV_Q_W-2:0], 1'b0};
            end
            n_den_sh = r_den_sh >> 1;
            n_cnt    = r_cnt + 1'b1;
            if (r_cnt == pcls_pkg::DIV_CNT_W'(pcls_pkg::DIV_Q_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem    <= n_rem;
        r_den_sh <= n_den_sh;
        r_q      <= n_q;
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

FILE: verif/tb_percentile_clip_linear_stretch.sv
`timescale 1ns / 1ps

module tb_percentile_clip_linear_stretch;
    import pcls_pkg::*;

    localparam int WATCHDOG_LIMIT = 200000;
    localparam int DRAIN_CYCLES   = 64;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [15:0] i_s_tdata;
    logic        i_s_tuser;
    logic        i_s_tlast;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [7:0]  o_m_tdata;
    logic        o_m_tlast;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [8:0]  i_cfg_data;

    percentile_clip_linear_stretch DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    typedef struct {
        logic [7:0] level;
        logic       final_pixel;
    } t_pixel_out;

    // predictor state
    logic [15:0]           frame_mem [MAX_PIXELS];
    int unsigned           hist_bins [NBINS];
    logic [PERMILLE_W-1:0] clip_pm;
    int unsigned           lo_sample, hi_sample, load_cnt, rd_ptr, lo_bound, hi_bound;
    logic                  reading;

    t_pixel_out pending_pixels[$];
    int         error_cnt;
    int         idle_cnt;
    bit         timed_out;

    // idling control
    int  src_idle_pct;
    int  snk_stall_pct;
    int  hold_off_cycles;

    function automatic void frame_restart();
        lo_sample = 16'hFFFF;
        hi_sample = 0;
        load_cnt  = 0;
        rd_ptr    = 0;
        reading   = 1'b0;
    endfunction

    function automatic void find_bounds();
        longint unsigned span, clip, acc, bin, v;
        int r;
        span = hi_sample - lo_sample;
        clip = (longint'(load_cnt) * clip_pm) / 1000;
        foreach (hist_bins[k]) hist_bins[k] = 0;
        for (int k = 0; k < load_cnt; k++) begin
            v   = frame_mem[k];
            bin = ((v - lo_sample) * NBINS) / (span + 1);
            if (bin >= NBINS) bin = NBINS - 1;
            hist_bins[bin]++;
        end
        lo_bound = 0;
        acc = 0;
        for (r = 0; r < NBINS; r++) begin
            acc += hist_bins[r];
            if (acc >= clip) begin
                lo_bound = ((r + 1) * span) / NBINS + lo_sample;
                break;
            end
        end
        hi_bound = 0;
        acc = 0;
        for (r = NBINS - 1; r >= 0; r--) begin
            acc += hist_bins[r];
            if (acc >= clip) begin
                hi_bound = (r * span) / NBINS + lo_sample;
                break;
            end
        end
        lo_bound &= 16'hFFFF;
        hi_bound &= 16'hFFFF;
    endfunction

    // advance the predictor by one accepted item
    function automatic void stretch_predict(logic cmd, logic [15:0] smp, logic fend);
        int unsigned p, lvl;
        bit last;
        t_pixel_out o;
        if (cmd == CMD_LOAD) begin
            if (reading) frame_restart();
            if (load_cnt < MAX_PIXELS) begin
                frame_mem[load_cnt] = smp;
                load_cnt++;
                if (smp < lo_sample) lo_sample = smp;
                if (smp > hi_sample) hi_sample = smp;
            end
            if (fend && load_cnt > 0) begin
                find_bounds();
                rd_ptr  = 0;
                reading = 1'b1;
            end
            return;
        end
        if (!reading || rd_ptr >= load_cnt) return;
        p    = frame_mem[rd_ptr];
        last = (rd_ptr + 1 == load_cnt);
        if (p <= lo_bound) lvl = 0;
        else if (p >= hi_bound) lvl = 255;
        else lvl = ((p - lo_bound) * 255) / (hi_bound - lo_bound);
        o.level       = lvl[7:0];
        o.final_pixel = last;
        pending_pixels.insert(pending_pixels.size(), o);
        rd_ptr++;
        if (last) frame_restart();
    endfunction

    // directed table: cmd, sample, frame_end, typed level (-1 = predictor only)
    typedef struct {
        logic        cmd;
        logic [15:0] smp;
        logic        fend;
        int          lvl;
    } t_row;

    t_row dir_rows[$];

    function automatic void add_row(logic cmd, logic [15:0] smp, logic fend, int lvl);
        t_row row;
        row.cmd  = cmd;
        row.smp  = smp;
        row.fend = fend;
        row.lvl  = lvl;
        dir_rows.insert(dir_rows.size(), row);
    endfunction

    // sender: one item, holds until accepted; valid drops only while idling
    task automatic send_item(logic cmd, logic [15:0] smp, logic fend);
        while (src_idle_pct > 0 && $urandom_range(99, 0) < src_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= cmd;
        i_s_tdata  <= smp;
        i_s_tlast  <= fend;
        do @(posedge i_clk); while (!o_s_tready);
        stretch_predict(cmd, smp, fend);
    endtask

    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        // a frame_end load may still be building bounds with no result due
        repeat (NBINS * 6 + 22 * 64 + 100) @(posedge i_clk);
    endtask

    task automatic write_permille(logic [8:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        clip_pm = val;
    endtask

    // frame of random samples then reads; sizes mostly small
    task automatic random_frame(int npix, int nread, int lo, int hi);
        for (int k = 0; k < npix; k++)
            send_item(CMD_LOAD, 16'($urandom_range(hi, lo)), k == npix - 1);
        for (int k = 0; k < nread; k++)
            send_item(CMD_READ, 16'($urandom), 1'($urandom));
    endtask

    // receiver stall and result check
    always @(posedge i_clk) begin
        t_pixel_out e;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                if (pending_pixels.size() == 0) begin
                    $display("%0t: unexpected result level=%0d last=%0b",
                             $time, o_m_tdata, o_m_tlast);
                    error_cnt++;
                end else begin
                    e = pending_pixels.pop_front();
                    if (o_m_tdata !== e.level || o_m_tlast !== e.final_pixel) begin
                        $display("%0t: mismatch expected level=%0d last=%0b actual level=%0d last=%0b",
                                 $time, e.level, e.final_pixel, o_m_tdata, o_m_tlast);
                        error_cnt++;
                    end
                end
            end
            if (hold_off_cycles > 0) begin
                hold_off_cycles <= hold_off_cycles - 1;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= !(snk_stall_pct > 0 && $urandom_range(99, 0) < snk_stall_pct);
            end
        end
    end

    // watchdog on cycles with no handshake at all
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (i_cfg_valid && o_cfg_ready))
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= WATCHDOG_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        int          dir_idx;
        logic [15:0] flip;
        error_cnt = 0;
        idle_cnt  = 0;
        timed_out = 1'b0;
        src_idle_pct    = 0;
        snk_stall_pct   = 0;
        hold_off_cycles = 0;
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tuser   = CMD_LOAD;
        i_s_tlast   = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        clip_pm = PERMILLE_RESET;
        frame_restart();
        lo_bound = 0;
        hi_bound = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // read while loading: ignored
        add_row(CMD_READ, 16'h1234, 1'b0, -1);
        // extremes frame: bounds land near 0 and 65535
        add_row(CMD_LOAD, 16'h0000, 1'b0, -1);
        add_row(CMD_LOAD, 16'hFFFF, 1'b0, -1);
        add_row(CMD_LOAD, 16'h8000, 1'b1, -1);
        add_row(CMD_READ, 16'h0000, 1'b0, 0);
        add_row(CMD_READ, 16'hFFFF, 1'b1, 255);
        add_row(CMD_READ, 16'h0000, 1'b0, -1);
        // read past frame end: ignored
        add_row(CMD_READ, 16'h0000, 1'b0, -1);
        // flat frame: equal bounds
        add_row(CMD_LOAD, 16'h0777, 1'b0, -1);
        add_row(CMD_LOAD, 16'h0777, 1'b1, -1);
        add_row(CMD_READ, 16'h0000, 1'b0, -1);
        add_row(CMD_READ, 16'h0000, 1'b0, -1);
        // single sample frame
        add_row(CMD_LOAD, 16'hFFFF, 1'b1, -1);
        add_row(CMD_READ, 16'h0000, 1'b0, -1);
        // load while reading abandons the frame
        add_row(CMD_LOAD, 16'h0010, 1'b0, -1);
        add_row(CMD_LOAD, 16'h0020, 1'b0, -1);
        add_row(CMD_LOAD, 16'h0030, 1'b1, -1);
        add_row(CMD_READ, 16'h0000, 1'b0, -1);
        add_row(CMD_LOAD, 16'h5555, 1'b0, -1);
        add_row(CMD_LOAD, 16'hAAAA, 1'b1, -1);
        add_row(CMD_READ, 16'h0000, 1'b0, -1);
        add_row(CMD_READ, 16'h0000, 1'b0, -1);

        for (dir_idx = 0; dir_idx < dir_rows.size(); dir_idx++) begin
            send_item(dir_rows[dir_idx].cmd, dir_rows[dir_idx].smp, dir_rows[dir_idx].fend);
            if (dir_rows[dir_idx].lvl >= 0 && pending_pixels.size() != 0 &&
                pending_pixels[$].level != 8'(dir_rows[dir_idx].lvl)) begin
                $display("%0t: mismatch expected level=%0d actual level=%0d (predictor)",
                         $time, dir_rows[dir_idx].lvl, pending_pixels[$].level);
                error_cnt++;
            end
        end
        wait_drained();

        // random phases with several permille settings
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 88; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 88; end
                default: begin src_idle_pct = 22; snk_stall_pct = 22; end
            endcase
            case (ph)
                0: write_permille(9'd0);
                1: write_permille(9'd500);
                2: write_permille(9'd511);
                3: write_permille(9'd1);
                4: write_permille(9'h0AA);
                5: write_permille(9'h155);
                6: write_permille(9'($urandom_range(500, 0)));
                default: write_permille(PERMILLE_RESET);
            endcase
            if (ph == 0) hold_off_cycles = 400;
            for (int f = 0; f < 6; f++) begin
                int n;
                n = $urandom_range(24, 2);
                case ($urandom_range(3, 0))
                    0: random_frame(n, n, 0, 65535);
                    1: random_frame(n, n + 2, 1000, 1100);
                    2: random_frame(n, $urandom_range(n - 1, 0), 0, 255);
                    default: begin
                        // noise and walking bits on the sample field
                        flip = 16'(1) << $urandom_range(15, 0);
                        random_frame(n, n, 0, 65535);
                        send_item(CMD_LOAD, flip, 1'b0);
                        send_item(CMD_LOAD, ~flip, 1'b1);
                        send_item(CMD_READ, 16'h0, 1'b0);
                    end
                endcase
            end
            wait_drained();
        end

        src_idle_pct  = 0;
        snk_stall_pct = 0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_cnt == 0 && pending_pixels.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/pcls_pkg.sv
hw/rtl/pcls_ram.sv
hw/rtl/pcls_div.sv
hw/rtl/percentile_clip_linear_stretch.sv
verif/tb_percentile_clip_linear_stretch.sv
